// File: rtl/core/prt_pkg.sv
// Shared types and constants for the peer registry table.
`timescale 1ns / 1ps
package prt_pkg;
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int LIST_MAX_DEF    = 10;
	localparam int QUEUE_DEPTH     = 2;
	localparam int ID_W            = 256;
	localparam int IP_W            = 32;
	localparam int PORT_W          = 16;
	localparam int TS_W            = 32;
	localparam int TMO_W           = 16;
	localparam int CNT_W           = 4;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd120;

	typedef enum logic [1:0] {
		CMD_REG  = 2'd0,
		CMD_CONN = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_HDR   = 2'd1,
		KIND_ENT   = 2'd2,
		KIND_RELAY = 2'd3
	} kind_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   node_id;
		logic [ID_W-1:0]   req_id;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TS_W-1:0]   now;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TS_W-1:0]   stamp;
	} slot_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic [IP_W-1:0]   peer_ip;
		logic [PORT_W-1:0] peer_port;
		logic [IP_W-1:0]   dest_ip;
		logic [PORT_W-1:0] dest_port;
		logic [CNT_W-1:0]  list_count;
		logic              last;
	} result_t;
endpackage

// File: rtl/core/prt_front.sv
// Front end: takes command beats, drops unknown commands, queues the rest.
`timescale 1ns / 1ps
module prt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  prt_pkg::item_t item_in,
	output logic           busy,
	output logic           q_valid,
	output prt_pkg::item_t q_item,
	input  logic           q_pop
);
	import prt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           fifo_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign busy    = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign push    = start && !busy && (item_in.cmd != CMD_NONE);
	assign pop     = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// File: rtl/core/prt_back.sv
// Back end: table memory, scan sequencer and result register.
`timescale 1ns / 1ps
module prt_back #(
	parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	parameter int LIST_MAX    = prt_pkg::LIST_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [prt_pkg::TMO_W-1:0]   timeout,
	input  logic                        q_valid,
	input  prt_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic                        res_valid,
	output prt_pkg::result_t            res
);
	import prt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN  = 9'b000000010,
		ST_STORE = 9'b000000100,
		ST_LIST  = 9'b000001000,
		ST_ACK   = 9'b000010000,
		ST_HDR   = 9'b000100000,
		ST_ERD   = 9'b001000000,
		ST_EOUT  = 9'b010000000,
		ST_RELAY = 9'b100000000
	} state_t;

	state_t              state_q;
	item_t               cur_q;
	slot_t               mem [TABLE_DEPTH];
	slot_t               rd_data_q;
	logic [AW-1:0]       rd_addr;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [AW:0]         cnt_q;
	logic                issue;
	logic                rd_v_s1;
	logic [AW-1:0]       rd_a_s1;
	logic                last_proc;
	logic                v_now;
	logic                id_eq;
	logic [TS_W-1:0]     age;

	logic                m_found_q, f_found_q, o_found_q;
	logic [AW-1:0]       m_slot_q, f_slot_q, o_slot_q;
	logic [TS_W-1:0]     o_age_q;
	logic [IP_W-1:0]     tgt_ip_q;
	logic [PORT_W-1:0]   tgt_port_q;
	logic                hit_found;
	logic [AW-1:0]       hit_slot;

	logic [AW-1:0]       list_q [LIST_MAX];
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    k_q;
	result_t             res_q;
	logic                res_valid_q;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_LIST)) &&
	                   (cnt_q < (AW+1)'(TABLE_DEPTH));
	assign last_proc = rd_v_s1 && (rd_a_s1 == AW'(TABLE_DEPTH - 1));
	assign rd_addr   = (state_q == ST_ERD) ? list_q[k_q[LW-1:0]] : cnt_q[AW-1:0];
	assign v_now     = valid_q[rd_a_s1];
	assign id_eq     = (rd_data_q.id == cur_q.node_id);
	assign age       = cur_q.now - rd_data_q.stamp;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// update, else first free slot, else oldest stamped before now
	always_comb begin
		hit_found = m_found_q || f_found_q || o_found_q;
		hit_slot  = m_found_q ? m_slot_q : (f_found_q ? f_slot_q : o_slot_q);
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if ((state_q == ST_STORE) && hit_found) begin
			mem[hit_slot] <= '{id: cur_q.node_id, ip: cur_q.ip, port: cur_q.port,
			                   stamp: cur_q.now};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		rd_a_s1 <= cnt_q[AW-1:0];
		if (rd_v_s1 && (state_q == ST_SCAN) && v_now && id_eq && !m_found_q) begin
			m_slot_q   <= rd_a_s1;
			tgt_ip_q   <= rd_data_q.ip;
			tgt_port_q <= rd_data_q.port;
		end
		if (rd_v_s1 && (state_q == ST_SCAN) && !v_now && !f_found_q) begin
			f_slot_q <= rd_a_s1;
		end
		if (rd_v_s1 && (state_q == ST_SCAN) && v_now && (age != '0) && !age[TS_W-1] &&
		    (!o_found_q || (age > o_age_q))) begin
			o_slot_q <= rd_a_s1;
			o_age_q  <= age;
		end
		if (rd_v_s1 && (state_q == ST_LIST) && v_now && !id_eq &&
		    (n_q < CNT_W'(LIST_MAX))) begin
			list_q[n_q[LW-1:0]] <= rd_a_s1;
		end
		unique case (state_q)
			ST_ACK: begin
				res_q <= '{kind: KIND_ACK, id: '0, peer_ip: '0, peer_port: '0,
				           dest_ip: cur_q.ip, dest_port: cur_q.port, list_count: '0,
				           last: (n_q == '0)};
			end
			ST_HDR: begin
				res_q <= '{kind: KIND_HDR, id: '0, peer_ip: '0, peer_port: '0,
				           dest_ip: cur_q.ip, dest_port: cur_q.port, list_count: n_q,
				           last: 1'b0};
			end
			ST_EOUT: begin
				res_q <= '{kind: KIND_ENT, id: rd_data_q.id, peer_ip: rd_data_q.ip,
				           peer_port: rd_data_q.port, dest_ip: cur_q.ip,
				           dest_port: cur_q.port, list_count: '0,
				           last: (k_q + 1'b1 == n_q)};
			end
			ST_RELAY: begin
				res_q <= '{kind: KIND_RELAY, id: cur_q.req_id, peer_ip: cur_q.ip,
				           peer_port: cur_q.port, dest_ip: tgt_ip_q,
				           dest_port: tgt_port_q, list_count: '0, last: 1'b1};
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			m_found_q   <= 1'b0;
			f_found_q   <= 1'b0;
			o_found_q   <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1     <= issue;
			res_valid_q <= (state_q == ST_ACK) || (state_q == ST_HDR) ||
			               (state_q == ST_EOUT) || (state_q == ST_RELAY);
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q     <= '0;
						m_found_q <= 1'b0;
						f_found_q <= 1'b0;
						o_found_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_v_s1) begin
						if (v_now && id_eq) begin
							m_found_q <= 1'b1;
						end
						if (!v_now) begin
							f_found_q <= 1'b1;
						end
						if (v_now && (age != '0) && !age[TS_W-1]) begin
							o_found_q <= 1'b1;
						end
						if ((cur_q.cmd == CMD_TICK) && v_now &&
						    (age > {{(TS_W-TMO_W){1'b0}}, timeout})) begin
							valid_q[rd_a_s1] <= 1'b0;
						end
					end
					if (last_proc) begin
						unique case (cur_q.cmd)
							CMD_REG:  state_q <= ST_STORE;
							CMD_CONN: state_q <= (m_found_q || (v_now && id_eq)) ?
							                     ST_RELAY : ST_IDLE;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_STORE: begin
					if (hit_found) begin
						valid_q[hit_slot] <= 1'b1;
					end
					cnt_q   <= '0;
					n_q     <= '0;
					state_q <= ST_LIST;
				end
				ST_LIST: begin
					if (rd_v_s1 && v_now && !id_eq && (n_q < CNT_W'(LIST_MAX))) begin
						n_q <= n_q + 1'b1;
					end
					if (last_proc) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					state_q <= (n_q == '0) ? ST_IDLE : ST_HDR;
				end
				ST_HDR: begin
					k_q     <= '0;
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 == n_q) ? ST_IDLE : ST_ERD;
				end
				ST_RELAY: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// File: rtl/core/peer_registry_table.sv
// Top level of the peer registry table.
`timescale 1ns / 1ps
// Peer registry table. A command beat is taken when start is high and busy is
// low; up to two beats queue ahead of the table sequencer. Each result beat shows
// for exactly one cycle on valid and cannot be stalled, so the receiver must take
// every beat. One table memory with a single registered read port sets the timing.
// A register command holds the sequencer for one scan to find the slot, a store,
// one scan to gather the list, an ack, and a header plus one read and one output
// per listed peer when any other peer is listed. A connect command with a known
// target scans the table and then relays; a tick or an unknown target only scans.
// A beat waits in the queue until the sequencer is idle, and each result
// leaves through one output register. Unknown commands are dropped on entry.
// The timeout, in seconds, is written from timeout_wdata through timeout_we.
module peer_registry_table #(
	parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	parameter int LIST_MAX    = prt_pkg::LIST_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        timeout_we,
	input  logic [15:0] timeout_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] node_id_w0,
	input  logic [63:0] node_id_w1,
	input  logic [63:0] node_id_w2,
	input  logic [63:0] node_id_w3,
	input  logic [63:0] req_id_w0,
	input  logic [63:0] req_id_w1,
	input  logic [63:0] req_id_w2,
	input  logic [63:0] req_id_w3,
	input  logic [31:0] src_ip,
	input  logic [15:0] src_port,
	input  logic [31:0] now_seconds,
	output logic        valid,
	output logic [1:0]  kind,
	output logic [63:0] id_w0,
	output logic [63:0] id_w1,
	output logic [63:0] id_w2,
	output logic [63:0] id_w3,
	output logic [31:0] peer_ip,
	output logic [15:0] peer_port,
	output logic [31:0] dest_ip,
	output logic [15:0] dest_port,
	output logic [3:0]  list_count,
	output logic        last
);
	import prt_pkg::*;

	logic [TMO_W-1:0] timeout_q;
	item_t            item_in;
	item_t            q_item;
	logic             q_valid;
	logic             q_pop;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	assign item_in = '{cmd: cmd_t'(cmd),
	                   node_id: {node_id_w3, node_id_w2, node_id_w1, node_id_w0},
	                   req_id: {req_id_w3, req_id_w2, req_id_w1, req_id_w0},
	                   ip: src_ip, port: src_port, now: now_seconds};

	prt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item_in (item_in),
		.busy    (busy),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	prt_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.LIST_MAX    (LIST_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.timeout   (timeout_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (valid),
		.res       (res)
	);

	assign kind       = res.kind;
	assign id_w0      = res.id[63:0];
	assign id_w1      = res.id[127:64];
	assign id_w2      = res.id[191:128];
	assign id_w3      = res.id[255:192];
	assign peer_ip    = res.peer_ip;
	assign peer_port  = res.peer_port;
	assign dest_ip    = res.dest_ip;
	assign dest_port  = res.dest_port;
	assign list_count = res.list_count;
	assign last       = res.last;
endmodule

// File: rtl/core/prt_checker.sv
// Port-level checks on result beats of the peer registry table, with bind.
`timescale 1ns / 1ps
module prt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic [1:0]  kind,
	input logic [3:0]  list_count,
	input logic        last
);
	import prt_pkg::*;

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_HDR) |-> (list_count != 4'd0) && !last)
		else $error("header beat with empty count or last set");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind != KIND_HDR) |-> (list_count == 4'd0))
		else $error("count set on a non-header beat");

	a_ack_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_ACK) && !last |=> valid && (kind == KIND_HDR))
		else $error("ack without last not followed by header");

	a_relay_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_RELAY) |-> last)
		else $error("relay beat not marked last");

	a_ent_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_ENT) |=> !valid)
		else $error("entry beats back to back");
endmodule

bind peer_registry_table prt_checker u_prt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (valid),
	.kind       (kind),
	.list_count (list_count),
	.last       (last)
);

// File: sim/tb_peer_registry_table.sv
// Testbench for the peer registry table: random and directed commands against a predictor.
`timescale 1ns / 1ps
module tb_peer_registry_table;
	import prt_pkg::*;

	localparam int DEPTH = 256;
	localparam int LMAX = 10;
	localparam int WDOG_LIMIT = 40000;

	typedef struct {
		kind_t       kind;
		logic [255:0] id;
		logic [31:0] pip;
		logic [15:0] pport;
		logic [31:0] dip;
		logic [15:0] dport;
		logic [3:0]  cnt;
		logic        lst;
	} beat_t;

	class registry_scoreboard;
		bit           tv [DEPTH];
		logic [255:0] tid [DEPTH];
		logic [31:0]  tip [DEPTH];
		logic [15:0]  tport [DEPTH];
		logic [31:0]  tstamp [DEPTH];
		logic [15:0]  tmo;
		beat_t        pending[$];
		int           errors;

		function new();
			foreach (tv[i]) tv[i] = 0;
			tmo = TIMEOUT_RST;
			errors = 0;
		endfunction

		function int find(logic [255:0] id);
			for (int s = 0; s < DEPTH; s++)
				if (tv[s] && tid[s] == id) return s;
			return -1;
		endfunction

		function beat_t mk(kind_t k, logic [255:0] id, logic [31:0] pip, logic [15:0] pp,
				logic [31:0] dip, logic [15:0] dp, logic [3:0] c, logic l);
			beat_t b;
			b.kind = k; b.id = id; b.pip = pip; b.pport = pp;
			b.dip = dip; b.dport = dp; b.cnt = c; b.lst = l;
			return b;
		endfunction

		function void note_item(cmd_t c, logic [255:0] nid, logic [255:0] rid,
				logic [31:0] ip, logic [15:0] port, logic [31:0] now);
			int hit, n;
			int lst [LMAX];
			logic [31:0] age, best;
			hit = -1;
			n = 0;
			best = 0;
			case (c)
				CMD_REG: begin
					hit = find(nid);
					if (hit < 0)
						for (int s = 0; s < DEPTH; s++)
							if (!tv[s]) begin hit = s; break; end
					if (hit < 0)
						for (int s = 0; s < DEPTH; s++) begin
							age = now - tstamp[s];
							if (tv[s] && age != 0 && !age[31] && age > best) begin
								best = age;
								hit = s;
							end
						end
					if (hit >= 0) begin
						tv[hit] = 1; tid[hit] = nid; tip[hit] = ip;
						tport[hit] = port; tstamp[hit] = now;
					end
					for (int s = 0; s < DEPTH && n < LMAX; s++)
						if (tv[s] && tid[s] != nid) begin lst[n] = s; n++; end
					pending.push_back(mk(KIND_ACK, 0, 0, 0, ip, port, 0, n == 0));
					if (n > 0) begin
						pending.push_back(mk(KIND_HDR, 0, 0, 0, ip, port, 4'(n), 0));
						for (int k = 0; k < n; k++)
							pending.push_back(mk(KIND_ENT, tid[lst[k]], tip[lst[k]],
								tport[lst[k]], ip, port, 0, k == n - 1));
					end
				end
				CMD_CONN: begin
					hit = find(nid);
					if (hit >= 0)
						pending.push_back(mk(KIND_RELAY, rid, ip, port, tip[hit],
							tport[hit], 0, 1));
				end
				CMD_TICK: begin
					for (int s = 0; s < DEPTH; s++)
						if (tv[s] && (now - tstamp[s]) > {16'd0, tmo}) tv[s] = 0;
				end
				default: ;
			endcase
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat kind=%0d", got.kind);
				return;
			end
			want = pending.pop_front();
			if (got.kind != want.kind || got.id != want.id || got.pip != want.pip ||
					got.pport != want.pport || got.dip != want.dip ||
					got.dport != want.dport || got.cnt != want.cnt || got.lst != want.lst) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: exp k%0d id=%h pip=%h pp=%h dip=%h dp=%h c=%0d l=%b",
						want.kind, want.id, want.pip, want.pport, want.dip, want.dport,
						want.cnt, want.lst);
					$display("  got k%0d id=%h pip=%h pp=%h dip=%h dp=%h c=%0d l=%b",
						got.kind, got.id, got.pip, got.pport, got.dip, got.dport,
						got.cnt, got.lst);
				end
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic timeout_we = 0;
	logic [15:0] timeout_wdata = 0;
	logic start = 0;
	logic busy;
	logic [1:0] cmd = 0;
	logic [63:0] node_id_w0 = 0, node_id_w1 = 0, node_id_w2 = 0, node_id_w3 = 0;
	logic [63:0] req_id_w0 = 0, req_id_w1 = 0, req_id_w2 = 0, req_id_w3 = 0;
	logic [31:0] src_ip = 0;
	logic [15:0] src_port = 0;
	logic [31:0] now_seconds = 0;
	logic valid;
	logic [1:0] kind;
	logic [63:0] id_w0, id_w1, id_w2, id_w3;
	logic [31:0] peer_ip, dest_ip;
	logic [15:0] peer_port, dest_port;
	logic [3:0] list_count;
	logic last;

	registry_scoreboard sb = new();
	int idle_cycles = 0;
	logic [255:0] known_ids [16];
	logic [31:0] clock_s = 1000;

	peer_registry_table DUT (
		.clk(clk), .arst_n(arst_n), .timeout_we(timeout_we), .timeout_wdata(timeout_wdata),
		.start(start), .busy(busy), .cmd(cmd),
		.node_id_w0(node_id_w0), .node_id_w1(node_id_w1),
		.node_id_w2(node_id_w2), .node_id_w3(node_id_w3),
		.req_id_w0(req_id_w0), .req_id_w1(req_id_w1),
		.req_id_w2(req_id_w2), .req_id_w3(req_id_w3),
		.src_ip(src_ip), .src_port(src_port), .now_seconds(now_seconds),
		.valid(valid), .kind(kind), .id_w0(id_w0), .id_w1(id_w1), .id_w2(id_w2),
		.id_w3(id_w3), .peer_ip(peer_ip), .peer_port(peer_port), .dest_ip(dest_ip),
		.dest_port(dest_port), .list_count(list_count), .last(last)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		beat_t b;
		if (valid) begin
			b.kind = kind_t'(kind);
			b.id = {id_w3, id_w2, id_w1, id_w0};
			b.pip = peer_ip; b.pport = peer_port;
			b.dip = dest_ip; b.dport = dest_port;
			b.cnt = list_count; b.lst = last;
			sb.check_beat(b);
		end
		if (valid || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_peer_registry_table: done, errors");
			$finish;
		end
	end

	function automatic logic [255:0] rand_id();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
	endfunction

	// start stays high into the next beat when there is no gap
	task automatic send(cmd_t c, logic [255:0] nid, logic [255:0] rid,
			logic [31:0] ip, logic [15:0] port, logic [31:0] now);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		cmd <= c;
		{node_id_w3, node_id_w2, node_id_w1, node_id_w0} <= nid;
		{req_id_w3, req_id_w2, req_id_w1, req_id_w0} <= rid;
		src_ip <= ip; src_port <= port; now_seconds <= now;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(c, nid, rid, ip, port, now);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		// up to three items with no result may still be queued or scanning
		repeat (3 * DEPTH + 40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		drain();
		timeout_we <= 1;
		timeout_wdata <= v;
		@(negedge clk);
		timeout_we <= 0;
		sb.tmo = v;
	endtask

	initial begin
		logic [255:0] ones;
		int r;
		cmd_t c;
		ones = '1;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (known_ids[i]) known_ids[i] = rand_id();

		// directed: empty-table ack, extremes, unknown target, ignored cmd
		send(CMD_CONN, known_ids[0], ones, 1, 2, 5);
		send(CMD_REG, 0, 0, 0, 0, 0);
		send(CMD_REG, ones, 0, '1, '1, '1);
		send(CMD_REG, known_ids[0], 0, 32'h0a000001, 16'd4000, 100);
		send(CMD_REG, known_ids[0], 0, 32'h0a000002, 16'd4001, 101);
		send(CMD_CONN, known_ids[0], ones, '1, '1, 102);
		send(CMD_CONN, ones, 0, 0, 0, 102);
		send(CMD_NONE, known_ids[1], ones, 7, 7, 103);
		send(CMD_TICK, 0, 0, 0, 0, 300);
		send(CMD_CONN, known_ids[0], 0, 3, 3, 301);
		set_timeout(16'hFFFF);
		for (int i = 1; i < 12; i++)
			send(CMD_REG, known_ids[i], 0, $urandom, 16'($urandom), 400 + i);
		send(CMD_TICK, 0, 0, 0, 0, 410);
		set_timeout(0);
		send(CMD_TICK, 0, 0, 0, 0, 406);

		// fill the table so replacement of the oldest slot is exercised
		set_timeout(120);
		for (int i = 0; i < DEPTH; i++)
			send(CMD_REG, rand_id(), 0, $urandom, 16'($urandom), 500 + (i % 7));
		send(CMD_REG, known_ids[2], 0, 1, 1, 503);
		send(CMD_REG, known_ids[3], 0, 1, 1, 500);
		send(CMD_REG, known_ids[4], 0, 1, 1, 32'h80000300);
		send(CMD_TICK, 0, 0, 0, 0, 1000);
		clock_s = 2000;

		for (int i = 0; i < 12; i++) begin
			if (i == 6) set_timeout(16'($urandom_range(5, 60)));
			r = $urandom_range(0, 99);
			clock_s += $urandom_range(0, 8);
			if (r < 55) c = CMD_REG;
			else if (r < 85) c = CMD_CONN;
			else if (r < 95) c = CMD_TICK;
			else c = CMD_NONE;
			send(c, ($urandom_range(0, 9) < 8) ? known_ids[$urandom_range(0, 15)] : rand_id(),
				rand_id(), $urandom, 16'($urandom),
				($urandom_range(0, 19) == 0) ? $urandom : clock_s);
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_peer_registry_table: done, clean");
		else
			$display("tb_peer_registry_table: done, errors");
		$finish;
	end
endmodule
